// ----- sv/tlbfa_pkg.sv -----
// ----------------------------------------------------------------------------
// tlbfa_pkg: shared types and constants for the fully associative TLB
// Beat layouts of both channels, the slot record handed along the cell
// chain, operation codes and register map.
// ----------------------------------------------------------------------------
`default_nettype none

package tlbfa_pkg;

    // Fixed field widths of the request and response beats
    localparam int VA_BITS     = 32;
    localparam int OFFSET_BITS = 12;
    localparam int PAGE_BITS   = VA_BITS - OFFSET_BITS;
    localparam int ENTRY_BITS  = 32;
    localparam int COUNT_BITS  = 32;
    localparam int OCC_BITS    = 5;
    localparam int CFG_BITS    = 5;

    // APB register map
    localparam int DATA_BITS  = 32;
    localparam int PADDR_BITS = 3;
    localparam logic REG_ACTIVE_ENTRIES = 1'b0;

    // Operation codes; the fourth code is a no-op
    localparam logic [1:0] MODE_LOOKUP = 2'd0;
    localparam logic [1:0] MODE_CACHE  = 2'd1;
    localparam logic [1:0] MODE_FLUSH  = 2'd2;

    typedef struct packed {
        logic [1:0]            mode;
        logic [VA_BITS-1:0]    vaddr;
        logic [ENTRY_BITS-1:0] new_entry;
    } tlbfa_req_t;

    typedef struct packed {
        logic                  hit;
        logic [ENTRY_BITS-1:0] entry_out;
        logic [OCC_BITS-1:0]   occupancy;
        logic [COUNT_BITS-1:0] recent_hit_count;
        logic [COUNT_BITS-1:0] recent_miss_count;
        logic [COUNT_BITS-1:0] total_hit_count;
        logic [COUNT_BITS-1:0] total_miss_count;
        logic [OCC_BITS-1:0]   recent_peak;
        logic [OCC_BITS-1:0]   total_peak;
    } tlbfa_rsp_t;

    typedef struct packed {
        logic                  valid;
        logic [PAGE_BITS-1:0]  page;
        logic [ENTRY_BITS-1:0] entry;
    } tlbfa_slot_t;

endpackage

`default_nettype wire

// ----- sv/tlbfa_cell.sv -----
// ----------------------------------------------------------------------------
// tlbfa_cell: one position of the recency stack
// Holds one translation, compares it against the broadcast page and, when
// told to advance, takes the record of its younger neighbor.
// ----------------------------------------------------------------------------
`default_nettype none

module tlbfa_cell (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              flush,
    input  wire logic                              advance,
    input  wire logic [tlbfa_pkg::PAGE_BITS-1:0]   page,
    input  wire tlbfa_pkg::tlbfa_slot_t            prev,
    output tlbfa_pkg::tlbfa_slot_t                 slot,
    output logic                                   match
);

    logic                                valid_reg;
    logic [tlbfa_pkg::PAGE_BITS-1:0]     page_reg;
    logic [tlbfa_pkg::ENTRY_BITS-1:0]    entry_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (flush)
        begin
            valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            valid_reg <= prev.valid;
        end
    end

    // Payload needs no reset; it is only looked at while valid
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            page_reg  <= prev.page;
            entry_reg <= prev.entry;
        end
    end

    assign slot.valid = valid_reg;
    assign slot.page  = page_reg;
    assign slot.entry = entry_reg;
    assign match      = valid_reg && (page_reg == page);

endmodule

`default_nettype wire

// ----- sv/tlbfa_apb.sv -----
// ----------------------------------------------------------------------------
// tlbfa_apb: APB register slice
// Holds the active entry limit; zero-wait writes and reads.
// ----------------------------------------------------------------------------
`default_nettype none

module tlbfa_apb #(
    parameter int ENTRIES = 16,
    parameter int RAW_W   = 5
) (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               psel,
    input  wire logic                               penable,
    input  wire logic                               pwrite,
    input  wire logic [tlbfa_pkg::PADDR_BITS-1:0]   paddr,
    input  wire logic [tlbfa_pkg::DATA_BITS-1:0]    pwdata,
    output logic      [tlbfa_pkg::DATA_BITS-1:0]    prdata,
    output logic                                    pready,
    output logic      [RAW_W-1:0]                   active_entries
);

    logic [RAW_W-1:0] active_entries_reg;
    logic [RAW_W-1:0] active_entries_next;
    logic             wr_en;

    assign wr_en = psel && penable && pwrite;

    always_comb
    begin
        active_entries_next = active_entries_reg;
        prdata              = '0;
        unique case (paddr[tlbfa_pkg::PADDR_BITS-1])
            tlbfa_pkg::REG_ACTIVE_ENTRIES:
            begin
                prdata = tlbfa_pkg::DATA_BITS'(active_entries_reg);
                if (wr_en)
                begin
                    active_entries_next =
                        RAW_W'(pwdata[tlbfa_pkg::CFG_BITS-1:0]);
                end
            end
            default:
            begin
                prdata = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_entries_reg <= RAW_W'(ENTRIES);
        end
        else
        begin
            active_entries_reg <= active_entries_next;
        end
    end

    assign pready         = 1'b1;
    assign active_entries = active_entries_reg;

endmodule

`default_nettype wire

// ----- sv/tlb_fully_associative_lru.sv -----
// ----------------------------------------------------------------------------
// tlb_fully_associative_lru: fully associative TLB with true LRU replacement
//
// Usage:
//   req channel (valid/ready) carries one operation per beat: lookup, cache
//   a translation, or flush; the offset bits of vaddr are ignored.
//   rsp channel (valid/ready) returns exactly one beat per request with the
//   hit flag, the entry on a lookup hit, the occupancy and all statistics.
//   The APB port holds active_entries (address 0), the number of slots the
//   replacement may fill; write it only while the block is idle.
// Latency and throughput: a response appears in the cycle after its request is
//   taken, and a new request is taken every cycle while the output register can
//   drain; the whole operation commits in a single pass over the cell chain.
// Stall: the response sits in an output register; while the receiver holds
//   rsp_ready low a further request is refused only if that register is
//   still full, so the chain never runs ahead of the consumer.
// Reset: all slots empty, counters and peaks zero, active_entries ENTRIES.
//   No clearing pass is needed; the block takes requests right after reset.
// ----------------------------------------------------------------------------
`default_nettype none

module tlb_fully_associative_lru #(
    parameter int ENTRIES = 16
) (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    // APB configuration port
    input  wire logic                               psel,
    input  wire logic                               penable,
    input  wire logic                               pwrite,
    input  wire logic [tlbfa_pkg::PADDR_BITS-1:0]   paddr,
    input  wire logic [tlbfa_pkg::DATA_BITS-1:0]    pwdata,
    output logic      [tlbfa_pkg::DATA_BITS-1:0]    prdata,
    output logic                                    pready,
    // request channel
    input  wire logic                               req_valid,
    output logic                                    req_ready,
    input  wire tlbfa_pkg::tlbfa_req_t              req,
    // response channel
    output logic                                    rsp_valid,
    input  wire logic                               rsp_ready,
    output tlbfa_pkg::tlbfa_rsp_t                   rsp
);

    // Occupancy spans 0..ENTRIES; the limit register is at least as wide
    // as the field written over APB.
    localparam int CNT_W = $clog2(ENTRIES + 1);
    localparam int RAW_W = (CNT_W > tlbfa_pkg::CFG_BITS) ? CNT_W : tlbfa_pkg::CFG_BITS;
    localparam logic [tlbfa_pkg::COUNT_BITS-1:0] SAT = '1;

    function automatic logic [tlbfa_pkg::COUNT_BITS-1:0] sat_inc(
        input logic [tlbfa_pkg::COUNT_BITS-1:0] v
    );
        return (v == SAT) ? v : v + 1'b1;
    endfunction

    // ------------------------------------------------------------------
    // Configuration
    // ------------------------------------------------------------------
    logic [RAW_W-1:0] active_entries;
    logic [RAW_W-1:0] limit;

    tlbfa_apb #(
        .ENTRIES (ENTRIES),
        .RAW_W   (RAW_W)
    ) u_apb (
        .clk            (clk),
        .rst_n          (rst_n),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready),
        .active_entries (active_entries)
    );

    // Zero acts as one, anything above the table size as the table size
    always_comb
    begin
        if (active_entries == '0)
        begin
            limit = RAW_W'(1);
        end
        else if (active_entries > RAW_W'(ENTRIES))
        begin
            limit = RAW_W'(ENTRIES);
        end
        else
        begin
            limit = active_entries;
        end
    end

    // ------------------------------------------------------------------
    // Handshake: the output register parts the two sides
    // ------------------------------------------------------------------
    logic accept;
    logic rsp_valid_reg;
    tlbfa_pkg::tlbfa_rsp_t rsp_reg;

    assign req_ready = !rsp_valid_reg || rsp_ready;
    assign accept    = req_valid && req_ready;

    // ------------------------------------------------------------------
    // Recency stack: cell 0 is most recent. Valid slots are always packed
    // at the front, so a slot's position is its LRU rank and the oldest
    // valid entry sits at position occupancy-1.
    // ------------------------------------------------------------------
    logic [tlbfa_pkg::PAGE_BITS-1:0]  req_page;
    tlbfa_pkg::tlbfa_slot_t           slot_q [ENTRIES];
    tlbfa_pkg::tlbfa_slot_t           front;
    logic [ENTRIES-1:0]               match;
    logic [ENTRIES-1:0]               slot_valid;
    logic [ENTRIES-1:0]               advance;
    logic [ENTRIES-1:0]               ins_span;
    logic [ENTRIES:0]                 tail;       // match at this position or older
    logic [tlbfa_pkg::ENTRY_BITS-1:0] hit_entry;

    assign req_page = req.vaddr[tlbfa_pkg::VA_BITS-1:tlbfa_pkg::OFFSET_BITS];

    // Operation decode
    logic op_lookup;
    logic op_cache;
    logic op_flush;

    always_comb
    begin
        op_lookup = 1'b0;
        op_cache  = 1'b0;
        op_flush  = 1'b0;
        unique case (req.mode)
            tlbfa_pkg::MODE_LOOKUP: op_lookup = 1'b1;
            tlbfa_pkg::MODE_CACHE:  op_cache  = 1'b1;
            tlbfa_pkg::MODE_FLUSH:  op_flush  = 1'b1;
            default:                op_lookup = 1'b0;   // no-op
        endcase
    end

    logic             hit_any;
    logic             do_promote;   // move a hit slot to the front
    logic             do_insert;    // push a new translation on the front
    logic             full;
    logic [CNT_W-1:0] occ_reg;
    logic [CNT_W-1:0] occ_next;
    logic [CNT_W-1:0] ins_pos;      // deepest cell that advances on insert

    assign hit_any    = tail[0];
    assign do_promote = (op_lookup || op_cache) && hit_any;
    assign do_insert  = op_cache && !hit_any;
    assign full       = RAW_W'(occ_reg) >= limit;
    // When full the oldest entry at occupancy-1 drops off the end
    assign ins_pos    = full ? occ_reg - 1'b1 : occ_reg;

    // Hit data: at most one cell matches
    always_comb
    begin
        hit_entry = '0;
        for (int i = 0; i < ENTRIES; i++)
        begin
            hit_entry = hit_entry | (slot_q[i].entry & {tlbfa_pkg::ENTRY_BITS{match[i]}});
        end
    end

    // Front record: the page itself on a hit or an insert
    assign front.valid = 1'b1;
    assign front.page  = req_page;
    assign front.entry = op_lookup ? hit_entry : req.new_entry;

    assign tail[ENTRIES] = 1'b0;

    for (genvar g = 0; g < ENTRIES; g++)
    begin : g_cell
        tlbfa_pkg::tlbfa_slot_t prev;

        assign tail[g]     = match[g] || tail[g+1];
        assign ins_span[g] = CNT_W'(g) <= ins_pos;
        // Cells from the front down to the hit position, or down to the
        // insert position, take their younger neighbor's record.
        assign advance[g]  = accept && ((do_promote && tail[g]) ||
                                        (do_insert && ins_span[g]));

        if (g == 0)
        begin : g_head
            assign prev = front;
        end
        else
        begin : g_body
            assign prev = slot_q[g-1];
        end

        tlbfa_cell u_cell (
            .clk     (clk),
            .rst_n   (rst_n),
            .flush   (accept && op_flush),
            .advance (advance[g]),
            .page    (req_page),
            .prev    (prev),
            .slot    (slot_q[g]),
            .match   (match[g])
        );

        assign slot_valid[g] = slot_q[g].valid;
    end

    // ------------------------------------------------------------------
    // Occupancy and statistics
    // ------------------------------------------------------------------
    logic [tlbfa_pkg::COUNT_BITS-1:0] hits_recent_reg,   hits_recent_next;
    logic [tlbfa_pkg::COUNT_BITS-1:0] misses_recent_reg, misses_recent_next;
    logic [tlbfa_pkg::COUNT_BITS-1:0] hits_total_reg,    hits_total_next;
    logic [tlbfa_pkg::COUNT_BITS-1:0] misses_total_reg,  misses_total_next;
    logic [CNT_W-1:0]                 peak_recent_reg,   peak_recent_next;
    logic [CNT_W-1:0]                 peak_total_reg,    peak_total_next;

    always_comb
    begin
        occ_next           = occ_reg;
        hits_recent_next   = hits_recent_reg;
        misses_recent_next = misses_recent_reg;
        hits_total_next    = hits_total_reg;
        misses_total_next  = misses_total_reg;
        peak_recent_next   = peak_recent_reg;

        if (op_flush)
        begin
            occ_next           = '0;
            hits_recent_next   = '0;
            misses_recent_next = '0;
            peak_recent_next   = '0;
        end
        else if (op_lookup)
        begin
            if (hit_any)
            begin
                hits_recent_next = sat_inc(hits_recent_reg);
                hits_total_next  = sat_inc(hits_total_reg);
            end
            else
            begin
                misses_recent_next = sat_inc(misses_recent_reg);
                misses_total_next  = sat_inc(misses_total_reg);
            end
        end
        else if (do_insert)
        begin
            if (!full)
            begin
                occ_next = occ_reg + 1'b1;
            end
            if (occ_next > peak_recent_reg)
            begin
                peak_recent_next = occ_next;
            end
        end

        peak_total_next = (peak_recent_next > peak_total_reg) ? peak_recent_next
                                                              : peak_total_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            occ_reg           <= '0;
            hits_recent_reg   <= '0;
            misses_recent_reg <= '0;
            hits_total_reg    <= '0;
            misses_total_reg  <= '0;
            peak_recent_reg   <= '0;
            peak_total_reg    <= '0;
        end
        else if (accept)
        begin
            occ_reg           <= occ_next;
            hits_recent_reg   <= hits_recent_next;
            misses_recent_reg <= misses_recent_next;
            hits_total_reg    <= hits_total_next;
            misses_total_reg  <= misses_total_next;
            peak_recent_reg   <= peak_recent_next;
            peak_total_reg    <= peak_total_next;
        end
    end

    // ------------------------------------------------------------------
    // Response register: load on accept, drop the beat once taken
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            rsp_valid_reg <= 1'b1;
        end
        else if (rsp_ready)
        begin
            rsp_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            rsp_reg.hit               <= op_lookup && hit_any;
            rsp_reg.entry_out         <= (op_lookup && hit_any) ? hit_entry : '0;
            rsp_reg.occupancy         <= tlbfa_pkg::OCC_BITS'(occ_next);
            rsp_reg.recent_hit_count  <= hits_recent_next;
            rsp_reg.recent_miss_count <= misses_recent_next;
            rsp_reg.total_hit_count   <= hits_total_next;
            rsp_reg.total_miss_count  <= misses_total_next;
            rsp_reg.recent_peak       <= tlbfa_pkg::OCC_BITS'(peak_recent_next);
            rsp_reg.total_peak        <= tlbfa_pkg::OCC_BITS'(peak_total_next);
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
`ifndef ASSERT_OFF
    // Occupancy count tracks the valid bits in the chain
    a_occ_count: assert property (@(posedge clk) disable iff (!rst_n)
        $countones(slot_valid) == int'(occ_reg))
        else $error("occupancy count out of step with valid cells");

    // Valid cells stay packed at the front of the stack
    a_packed: assert property (@(posedge clk) disable iff (!rst_n)
        ((slot_valid + 1'b1) & slot_valid) == '0)
        else $error("hole in the recency stack");

    // A page is held at most once
    a_unique: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0(match))
        else $error("page present in more than one cell");

    // A flush empties the table
    a_flush: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && op_flush) |=> (slot_valid == '0))
        else $error("valid cell left after flush");
`endif

endmodule

`default_nettype wire

// ----- test/testbench.sv -----
// ----------------------------------------------------------------------------
// testbench: self-checking regression for tlb_fully_associative_lru
// Drives lookup, cache, flush and no-op beats through the valid/ready request
// channel, programs active_entries over APB between phases, and checks every
// response beat against an in-bench LRU table model held in a scoreboard.
// ----------------------------------------------------------------------------
`default_nettype none

module testbench;

    import tlbfa_pkg::*;

    // The unused fourth operation code has no name in the package
    localparam logic [1:0] MODE_NOP = 2'd3;
    localparam int SLOTS = 16;
    localparam int PHASE_ITEMS = 160;
    localparam logic [PADDR_BITS-1:0] ACTIVE_ADDR =
        PADDR_BITS'(4 * int'(REG_ACTIVE_ENTRIES));

    // ------------------------------------------------------------------------
    // Scoreboard: shadow LRU table plus the queue of predicted response beats
    // ------------------------------------------------------------------------
    class tlb_scoreboard;
        bit                    slot_used[SLOTS];
        logic [PAGE_BITS-1:0]  slot_vpn[SLOTS];
        logic [ENTRY_BITS-1:0] slot_pte[SLOTS];
        int unsigned           slot_rank[SLOTS];
        logic [CFG_BITS-1:0]   active_entries;
        logic [COUNT_BITS-1:0] hits_recent, misses_recent, hits_total, misses_total;
        int unsigned           peak_recent, peak_total;
        tlbfa_rsp_t            expected_q[$];
        int                    failures;

        function new();
            foreach (slot_used[i]) slot_used[i] = 1'b0;
            active_entries = CFG_BITS'(SLOTS);
            hits_recent = '0;
            misses_recent = '0;
            hits_total = '0;
            misses_total = '0;
            peak_recent = 0;
            peak_total = 0;
            failures = 0;
        endfunction

        function void set_active(logic [CFG_BITS-1:0] value);
            active_entries = value;
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        function logic [COUNT_BITS-1:0] sat_bump(logic [COUNT_BITS-1:0] v);
            return (&v) ? v : v + 1'b1;
        endfunction

        function int unsigned count_used();
            int unsigned n;
            n = 0;
            foreach (slot_used[i]) if (slot_used[i]) n++;
            return n;
        endfunction

        function int find_vpn(logic [PAGE_BITS-1:0] vpn);
            foreach (slot_used[i]) if (slot_used[i] && slot_vpn[i] == vpn) return i;
            return -1;
        endfunction

        // Make slot s most recent; entries younger than its old rank age by one
        function void promote(int s, int unsigned old_rank);
            foreach (slot_used[i])
                if (slot_used[i] && i != s && slot_rank[i] < old_rank) slot_rank[i]++;
            slot_rank[s] = 0;
        endfunction

        function void note_request(tlbfa_req_t r);
            logic [PAGE_BITS-1:0] vpn;
            int unsigned          limit, occ, best, old_rank;
            int                   s, t;
            tlbfa_rsp_t           e;
            vpn = r.vaddr[VA_BITS-1:OFFSET_BITS];
            limit = active_entries;
            if (limit == 0) limit = 1;
            if (limit > SLOTS) limit = SLOTS;
            e = '0;
            case (r.mode)
                MODE_LOOKUP:
                begin
                    s = find_vpn(vpn);
                    if (s >= 0)
                    begin
                        e.hit = 1'b1;
                        e.entry_out = slot_pte[s];
                        hits_recent = sat_bump(hits_recent);
                        hits_total = sat_bump(hits_total);
                        promote(s, slot_rank[s]);
                    end
                    else
                    begin
                        misses_recent = sat_bump(misses_recent);
                        misses_total = sat_bump(misses_total);
                    end
                end
                MODE_CACHE:
                begin
                    s = find_vpn(vpn);
                    if (s >= 0)
                    begin
                        slot_pte[s] = r.new_entry;
                        promote(s, slot_rank[s]);
                    end
                    else
                    begin
                        occ = count_used();
                        t = -1;
                        best = 0;
                        if (occ >= limit)
                        begin
                            // full (or over a lowered limit): reuse the oldest slot
                            foreach (slot_used[i])
                                if (slot_used[i] && (t < 0 || slot_rank[i] > best))
                                begin
                                    t = i;
                                    best = slot_rank[i];
                                end
                        end
                        else
                        begin
                            foreach (slot_used[i]) if (!slot_used[i] && t < 0) t = i;
                        end
                        old_rank = slot_used[t] ? slot_rank[t] : 32'hFFFF_FFFF;
                        slot_used[t] = 1'b1;
                        slot_vpn[t] = vpn;
                        slot_pte[t] = r.new_entry;
                        promote(t, old_rank);
                        occ = count_used();
                        if (occ > peak_recent) peak_recent = occ;
                        if (peak_recent > peak_total) peak_total = peak_recent;
                    end
                end
                MODE_FLUSH:
                begin
                    foreach (slot_used[i]) slot_used[i] = 1'b0;
                    hits_recent = '0;
                    misses_recent = '0;
                    peak_recent = 0;
                end
                default: ;
            endcase
            e.occupancy = OCC_BITS'(count_used());
            e.recent_hit_count = hits_recent;
            e.recent_miss_count = misses_recent;
            e.total_hit_count = hits_total;
            e.total_miss_count = misses_total;
            e.recent_peak = OCC_BITS'(peak_recent);
            e.total_peak = OCC_BITS'(peak_total);
            expected_q.push_back(e);
        endfunction

        function void compare_field(string name, logic [31:0] want, logic [31:0] got);
            if (got !== want)
            begin
                $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
                failures++;
            end
        endfunction

        function void check_response(tlbfa_rsp_t got);
            tlbfa_rsp_t want;
            if (expected_q.size() == 0)
            begin
                $display("%0t: unexpected response beat, expected none, actual %h", $time, got);
                failures++;
                return;
            end
            want = expected_q.pop_front();
            compare_field("hit", 32'(want.hit), 32'(got.hit));
            compare_field("entry_out", want.entry_out, got.entry_out);
            compare_field("occupancy", 32'(want.occupancy), 32'(got.occupancy));
            compare_field("recent_hit_count", want.recent_hit_count, got.recent_hit_count);
            compare_field("recent_miss_count", want.recent_miss_count, got.recent_miss_count);
            compare_field("total_hit_count", want.total_hit_count, got.total_hit_count);
            compare_field("total_miss_count", want.total_miss_count, got.total_miss_count);
            compare_field("recent_peak", 32'(want.recent_peak), 32'(got.recent_peak));
            compare_field("total_peak", 32'(want.total_peak), 32'(got.total_peak));
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // Signals and the block under test
    // ------------------------------------------------------------------------
    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  psel, penable, pwrite;
    logic [PADDR_BITS-1:0] paddr;
    logic [DATA_BITS-1:0]  pwdata;
    logic [DATA_BITS-1:0]  prdata;
    logic                  pready;
    logic                  req_valid, req_ready;
    tlbfa_req_t            req;
    logic                  rsp_valid, rsp_ready;
    tlbfa_rsp_t            rsp;

    tlb_scoreboard         sb;
    logic [PAGE_BITS-1:0]  page_pool[24];
    bit                    src_eager;
    bit                    sink_eager;
    bit                    hold_off_req;

    tlb_fully_associative_lru dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // Request side helpers; every task starts and ends at a falling edge
    // ------------------------------------------------------------------------
    function automatic tlbfa_req_t make_item(logic [1:0] mode, logic [VA_BITS-1:0] vaddr,
                                             logic [ENTRY_BITS-1:0] pte);
        tlbfa_req_t r;
        r.mode = mode;
        r.vaddr = vaddr;
        r.new_entry = pte;
        return r;
    endfunction

    // Mostly lookups and caches over a small page pool so that hits, refreshes
    // and evictions all occur; a few wild addresses, flushes and no-ops as noise.
    function automatic tlbfa_req_t random_item(int pool_len);
        tlbfa_req_t r;
        int         pick;
        pick = $urandom_range(0, 99);
        r.new_entry = $urandom();
        r.vaddr = {page_pool[$urandom_range(0, pool_len - 1)], OFFSET_BITS'($urandom())};
        if (pick < 50)
            r.mode = MODE_LOOKUP;
        else if (pick < 90)
            r.mode = MODE_CACHE;
        else if (pick < 95)
        begin
            r.mode = MODE_LOOKUP;
            r.vaddr = $urandom();
        end
        else if (pick < 98)
            r.mode = MODE_FLUSH;
        else
            r.mode = MODE_NOP;
        return r;
    endfunction

    // Offer one request beat after a random gap; hold it until accepted
    task automatic send_item(input tlbfa_req_t r);
        int gap;
        gap = src_eager ? 0 : $urandom_range(0, 14);
        if (gap > 0)
        begin
            req_valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        req = r;
        req_valid = 1'b1;
        do @(posedge clk); while (!req_ready);
        sb.note_request(r);
        @(negedge clk);
    endtask

    // Drop valid and wait for every predicted response beat to come back
    task automatic wait_drained();
        req_valid = 1'b0;
        while (sb.pending() > 0) @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    // Two-phase APB write of active_entries; upper data bits are don't-care
    task automatic write_active(input logic [CFG_BITS-1:0] value);
        logic [DATA_BITS-1:0] word;
        word = $urandom();
        word[CFG_BITS-1:0] = value;
        psel = 1'b1;
        penable = 1'b0;
        pwrite = 1'b1;
        paddr = ACTIVE_ADDR;
        pwdata = word;
        @(negedge clk);
        penable = 1'b1;
        do @(posedge clk); while (!pready);
        sb.set_active(value);
        @(negedge clk);
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
    endtask

    // ------------------------------------------------------------------------
    // Response side: random stalls, bursts with ready held high, and one long
    // hold-off on request so the output register fills and req_ready drops
    // ------------------------------------------------------------------------
    initial
    begin : sink
        int gap;
        rsp_ready = 1'b0;
        sink_eager = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_off_req)
            begin
                hold_off_req = 1'b0;
                rsp_ready = 1'b0;
                repeat (300) @(negedge clk);
            end
            if ($urandom_range(0, 29) == 0) sink_eager = !sink_eager;
            gap = sink_eager ? 0 : $urandom_range(0, 14);
            if (gap > 0)
            begin
                rsp_ready = 1'b0;
                repeat (gap) @(negedge clk);
            end
            rsp_ready = 1'b1;
            do @(posedge clk); while (!rsp_valid);
            sb.check_response(rsp);
        end
    end

    // ------------------------------------------------------------------------
    // Watchdog: far beyond the slowest legal run
    // ------------------------------------------------------------------------
    initial
    begin : watchdog
        #10_000_000;
        $display("tlb_fully_associative_lru regression: fail");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial
    begin : stimulus
        int          phase_limits[10];
        int unsigned eff;
        int          pool_len;
        sb = new();
        rst_n = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        req_valid = 1'b0;
        req = '0;
        hold_off_req = 1'b0;
        src_eager = 1'b0;
        // 0 and 31 exercise the clamps; 5 after 16 lowers the limit under a
        // full table without a flush
        phase_limits = '{1, 0, 31, 2, 16, 5, 20, 8, 3, 16};
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Directed: empty miss, extreme pages and entries, refresh of a
        // present page, no-op, flush and the miss that follows it
        send_item(make_item(MODE_LOOKUP, 32'h0000_0000, 32'hFFFF_FFFF));
        send_item(make_item(MODE_CACHE,  32'h0000_0FFF, 32'hFFFF_FFFF));
        send_item(make_item(MODE_LOOKUP, 32'h0000_0123, 32'h0000_0000));
        send_item(make_item(MODE_CACHE,  32'hFFFF_FFFF, 32'h0000_0000));
        send_item(make_item(MODE_LOOKUP, 32'hFFFF_F000, 32'hFFFF_FFFF));
        send_item(make_item(MODE_CACHE,  32'h0000_0000, 32'hA5A5_5A5A));
        send_item(make_item(MODE_LOOKUP, 32'h0000_0ABC, 32'h1234_5678));
        send_item(make_item(MODE_LOOKUP, 32'hFFFF_FFFF, 32'h0000_0000));
        send_item(make_item(MODE_CACHE,  32'h8000_1000, 32'h5A5A_A5A5));
        send_item(make_item(MODE_LOOKUP, 32'h0000_1000, 32'h0000_0000));
        send_item(make_item(MODE_NOP,    32'hFFFF_FFFF, 32'hFFFF_FFFF));
        send_item(make_item(MODE_FLUSH,  32'h0000_0000, 32'h0000_0000));
        send_item(make_item(MODE_LOOKUP, 32'hFFFF_F123, 32'h0000_0000));
        send_item(make_item(MODE_LOOKUP, 32'h0000_0000, 32'h0000_0000));
        send_item(make_item(MODE_CACHE,  32'h1234_5678, 32'h8765_4321));
        send_item(make_item(MODE_LOOKUP, 32'h1234_5FFF, 32'h0000_0000));
        wait_drained();

        // Random phases, each with its own table limit and page pool
        foreach (phase_limits[p])
        begin
            write_active(CFG_BITS'(phase_limits[p]));
            eff = phase_limits[p];
            if (eff == 0) eff = 1;
            if (eff > SLOTS) eff = SLOTS;
            pool_len = eff + 4;
            foreach (page_pool[k]) page_pool[k] = PAGE_BITS'($urandom());
            src_eager = (p == 4) || ($urandom_range(0, 3) == 0);
            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                // Stall the receiver while the sender keeps pushing
                if (p == 4 && n == 10) hold_off_req = 1'b1;
                // Now and then pause the sender until everything has drained
                if (n == PHASE_ITEMS / 2 && $urandom_range(0, 1) == 0) wait_drained();
                send_item(random_item(pool_len));
            end
            wait_drained();
        end

        if (sb.failures == 0 && sb.pending() == 0)
            $display("tlb_fully_associative_lru regression: pass");
        else
            $display("tlb_fully_associative_lru regression: fail");
        $finish;
    end

endmodule

`default_nettype wire

// ----- files.f -----
sv/tlbfa_pkg.sv
sv/tlbfa_cell.sv
sv/tlbfa_apb.sv
sv/tlb_fully_associative_lru.sv
test/testbench.sv
